### design/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types, constants and hash helpers of the count-min sketch engine.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam int ROWS         = 4;
    localparam int COLUMNS      = 1024;
    localparam int COUNTER_BITS = 32;
    localparam int KEY_BYTES    = 13;
    localparam int DEPTH        = ROWS * COLUMNS;
    localparam int ADDR_W       = $clog2(DEPTH);
    localparam int COL_W        = $clog2(COLUMNS);
    localparam int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [63:0] SPOOKY_CONST = 64'hdeadbeefdeadbeef;

    typedef enum logic [1:0] {
        MODE_UPDATE = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_ROWS  = 3'd0,
        CFG_COLS  = 3'd1,
        CFG_SEED0 = 3'd2,
        CFG_SEED1 = 3'd3,
        CFG_SEED2 = 3'd4,
        CFG_SEED3 = 3'd5
    } cfg_idx_t;

    // Classified request passed from front to back
    typedef struct packed {
        mode_t        mode;
        logic [103:0] key;
    } req_t;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int k);
        rotl = (x << k) | (x >> (64 - k));
    endfunction

endpackage

### design/cms_ram.sv
// ----------------------------------------------------------------------------
// cms_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/cms_front.sv
// ----------------------------------------------------------------------------
// cms_front
// Accepts input requests, packs the key and holds them in a short queue.
// ----------------------------------------------------------------------------
module cms_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_mode,
    input  logic [103:0]  s_key,
    output logic          q_valid,
    input  logic          q_ready,
    output cms_pkg::req_t q_req
);

    localparam int PW = $clog2(cms_pkg::QUEUE_DEPTH);

    cms_pkg::req_t    slot_reg [cms_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wp_reg, rp_reg;
    logic [PW:0]      cnt_reg;
    logic             push, pop;

    assign s_ready = (cnt_reg != (PW+1)'(cms_pkg::QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_req   = slot_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // Store the classified request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg].mode <= cms_pkg::mode_t'(s_mode);
            slot_reg[wp_reg].key  <= s_key;
        end
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + PW'(1);
            end
            if (pop)
            begin
                rp_reg <= rp_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(cms_pkg::QUEUE_DEPTH))
        else $error("queue overfilled");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == (PW+1)'(cms_pkg::QUEUE_DEPTH)) |-> !push)
        else $error("push into full queue");
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - (PW+1)'(1)))
        else $error("pop miscounted");

endmodule

### design/cms_back.sv
// ----------------------------------------------------------------------------
// cms_back
// Executes requests: per row hash rounds, modulo, counter read-modify-write.
// ----------------------------------------------------------------------------
module cms_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  cms_pkg::req_t q_req,
    input  logic [2:0]    rows_in_use,
    input  logic [10:0]   counters_per_row,
    input  logic [127:0]  seeds,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [31:0]   estimate
);

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_HASH  = 10'b0000000100,
        ST_MOD   = 10'b0000001000,
        ST_ADDR  = 10'b0000010000,
        ST_READ  = 10'b0000100000,
        ST_WRITE = 10'b0001000000,
        ST_NEXT  = 10'b0010000000,
        ST_OUT   = 10'b0100000000,
        ST_WIPE  = 10'b1000000000
    } state_t;

    localparam int AW = cms_pkg::ADDR_W;

    state_t                  state_reg, state_next;
    cms_pkg::req_t           req_reg;
    logic [63:0]             h0_reg, h1_reg, h2_reg, h3_reg;
    logic [3:0]              step_reg;
    logic [cms_pkg::ROW_W:0] row_reg;
    logic [cms_pkg::ROW_W:0] rows_eff;
    logic [11:0]             cols_eff;
    logic [31:0]             rem_reg;
    logic [5:0]              bit_reg;
    logic [31:0]             hash_reg;
    logic [AW-1:0]           base_reg;
    logic [AW-1:0]           addr_reg;
    logic [AW:0]             wipe_reg;
    logic [31:0]             best_reg;
    logic [31:0]             out_reg;
    logic                    out_valid_reg;
    logic [31:0]             rdata;
    logic                    we;
    logic [AW-1:0]           waddr;
    logic [31:0]             wdata;
    logic [63:0]             e0, e1, e2, e3;
    logic [31:0]             rem_shift;
    logic [31:0]             seed_sel;
    logic [AW+12:0]          idx_full;

    // Clamp the configuration
    always_comb
    begin
        rows_eff = (rows_in_use == 3'd0) ? (cms_pkg::ROW_W+1)'(1) :
                   ({1'b0, rows_in_use} > 4'(cms_pkg::ROWS)) ?
                   (cms_pkg::ROW_W+1)'(cms_pkg::ROWS) : (cms_pkg::ROW_W+1)'(rows_in_use);
        cols_eff = (counters_per_row == 11'd0) ? 12'd1 :
                   ({1'b0, counters_per_row} > 12'(cms_pkg::COLUMNS)) ?
                   12'(cms_pkg::COLUMNS) : {1'b0, counters_per_row};
    end

    always_comb
    begin
        seed_sel = 32'(row_reg);
        if (row_reg < 4)
        begin
            seed_sel = seeds[32*row_reg[1:0] +: 32];
        end
    end

    // One end4 line per cycle
    always_comb
    begin
        e0 = h0_reg; e1 = h1_reg; e2 = h2_reg; e3 = h3_reg;
        case (step_reg)
            4'd0:    begin e3 = h3_reg ^ h2_reg; e2 = cms_pkg::rotl(h2_reg, 15);
                           e3 = e3 + e2; end
            4'd1:    begin e0 = h0_reg ^ h3_reg; e3 = cms_pkg::rotl(h3_reg, 52);
                           e0 = e0 + e3; end
            4'd2:    begin e1 = h1_reg ^ h0_reg; e0 = cms_pkg::rotl(h0_reg, 26);
                           e1 = e1 + e0; end
            4'd3:    begin e2 = h2_reg ^ h1_reg; e1 = cms_pkg::rotl(h1_reg, 51);
                           e2 = e2 + e1; end
            4'd4:    begin e3 = h3_reg ^ h2_reg; e2 = cms_pkg::rotl(h2_reg, 28);
                           e3 = e3 + e2; end
            4'd5:    begin e0 = h0_reg ^ h3_reg; e3 = cms_pkg::rotl(h3_reg, 9);
                           e0 = e0 + e3; end
            4'd6:    begin e1 = h1_reg ^ h0_reg; e0 = cms_pkg::rotl(h0_reg, 47);
                           e1 = e1 + e0; end
            4'd7:    begin e2 = h2_reg ^ h1_reg; e1 = cms_pkg::rotl(h1_reg, 54);
                           e2 = e2 + e1; end
            4'd8:    begin e3 = h3_reg ^ h2_reg; e2 = cms_pkg::rotl(h2_reg, 32);
                           e3 = e3 + e2; end
            4'd9:    begin e0 = h0_reg ^ h3_reg; e3 = cms_pkg::rotl(h3_reg, 25);
                           e0 = e0 + e3; end
            4'd10:   begin e1 = h1_reg ^ h0_reg; e0 = cms_pkg::rotl(h0_reg, 63);
                           e1 = e1 + e0; end
            default: begin e0 = h0_reg; end
        endcase
    end

    // Restoring remainder step, one hash bit per cycle
    assign rem_shift = {rem_reg[30:0], hash_reg[bit_reg[4:0]]};
    assign idx_full  = (AW+13)'(base_reg) + (AW+13)'(rem_reg);

    assign q_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_valid  = out_valid_reg;
    assign estimate = out_reg;

    always_comb
    begin
        we    = 1'b0;
        waddr = addr_reg;
        wdata = rdata + 32'd1;
        if (state_reg == ST_CLEAR || state_reg == ST_WIPE)
        begin
            we    = 1'b1;
            waddr = wipe_reg[AW-1:0];
            wdata = '0;
        end
        else if (state_reg == ST_WRITE && req_reg.mode == cms_pkg::MODE_UPDATE)
        begin
            we = 1'b1;
        end
    end

    cms_ram #(.WIDTH(cms_pkg::COUNTER_BITS), .DEPTH(cms_pkg::DEPTH)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR, ST_WIPE:
                if (wipe_reg == (AW+1)'(cms_pkg::DEPTH - 1))
                begin
                    state_next = (state_reg == ST_WIPE) ? ST_OUT : ST_IDLE;
                end
            ST_IDLE:
                if (q_valid && q_ready)
                begin
                    case (q_req.mode)
                        cms_pkg::MODE_UPDATE, cms_pkg::MODE_QUERY: state_next = ST_HASH;
                        cms_pkg::MODE_CLEAR:  state_next = ST_WIPE;
                        default:              state_next = ST_OUT;
                    endcase
                end
            ST_HASH:  if (step_reg == 4'd10) state_next = ST_MOD;
            ST_MOD:   if (bit_reg == 6'd0) state_next = ST_ADDR;
            ST_ADDR:  state_next = (idx_full < (AW+13)'(cms_pkg::DEPTH)) ? ST_READ : ST_NEXT;
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_NEXT;
            ST_NEXT:  state_next = (row_reg + 1'b1 == rows_eff) ? ST_OUT : ST_HASH;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            wipe_reg      <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            row_reg       <= '0;
            bit_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_valid && m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR, ST_WIPE: wipe_reg <= wipe_reg + 1'b1;
                ST_IDLE:
                begin
                    wipe_reg <= '0;
                    row_reg  <= '0;
                    step_reg <= '0;
                end
                ST_HASH:
                begin
                    step_reg <= step_reg + 4'd1;
                    bit_reg  <= 6'd31;
                end
                ST_MOD:  bit_reg <= bit_reg - 6'd1;
                ST_NEXT:
                begin
                    row_reg  <= row_reg + 1'b1;
                    step_reg <= '0;
                end
                ST_OUT:  out_valid_reg <= 1'b1;
                default: step_reg <= step_reg;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                req_reg  <= q_req;
                best_reg <= '0;
                base_reg <= '0;
            end
            ST_HASH:
            begin
                if (step_reg == 4'd0)
                begin
                    // Load the seeded state and run the first end4 line
                    h0_reg <= {32'd0, seed_sel};
                    h1_reg <= {32'd0, seed_sel};
                    h2_reg <= cms_pkg::rotl(cms_pkg::SPOOKY_CONST + req_reg.key[63:0], 15);
                    h3_reg <= ((cms_pkg::SPOOKY_CONST + {24'd0, req_reg.key[103:64]}
                               + (64'(cms_pkg::KEY_BYTES) << 56))
                               ^ (cms_pkg::SPOOKY_CONST + req_reg.key[63:0]))
                               + cms_pkg::rotl(cms_pkg::SPOOKY_CONST + req_reg.key[63:0], 15);
                end
                else
                begin
                    h0_reg <= e0; h1_reg <= e1; h2_reg <= e2; h3_reg <= e3;
                end
                rem_reg <= '0;
                if (step_reg == 4'd10)
                begin
                    hash_reg <= e0[31:0];
                end
            end
            ST_MOD:
                rem_reg <= ({1'b0, rem_shift} >= {21'd0, cols_eff}) ?
                           rem_shift - {20'd0, cols_eff} : rem_shift;
            ST_ADDR:  addr_reg <= idx_full[AW-1:0];
            ST_WRITE:
                if (req_reg.mode == cms_pkg::MODE_QUERY && (row_reg == '0 || rdata < best_reg))
                begin
                    best_reg <= rdata;
                end
            ST_NEXT:  base_reg <= base_reg + AW'(cols_eff);
            ST_OUT:   out_reg <= (req_reg.mode == cms_pkg::MODE_QUERY) ? best_reg : '0;
            default:  out_reg <= out_reg;
        endcase
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !q_ready)
        else $error("took request while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid && !m_ready) |=> (m_valid && $stable(estimate)))
        else $error("result dropped");

endmodule

### design/count_min_sketch_engine.sv
// ----------------------------------------------------------------------------
// count_min_sketch_engine
// Count-min sketch over a 13-byte flow key with SpookyHash V2 row hashes.
// ----------------------------------------------------------------------------
// An update or query runs, for each row in use, 11 hash rounds, 32 remainder
// steps of the bit-serial modulo unit, then address, read, write and row
// advance through the store's read and write ports. A clear sweeps the
// 4096-entry store one counter a cycle; after reset the same pass runs
// before the first request is taken. Each request gives one result on the
// master side.
module count_min_sketch_engine (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // key_low[63:0], key_high[103:64]
    input  logic [1:0]   s_axis_tuser,   // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // estimate
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    cms_pkg::req_t q_req;
    logic          q_valid, q_ready;
    logic [2:0]    rows_reg;
    logic [10:0]   cols_reg;
    logic [127:0]  seeds_reg;

    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= 3'd4;
            cols_reg  <= 11'd1024;
            seeds_reg <= {32'd3, 32'd2, 32'd1, 32'd0};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cms_pkg::CFG_ROWS:  rows_reg <= cfg_data[2:0];
                cms_pkg::CFG_COLS:  cols_reg <= cfg_data[10:0];
                cms_pkg::CFG_SEED0: seeds_reg[31:0]   <= cfg_data;
                cms_pkg::CFG_SEED1: seeds_reg[63:32]  <= cfg_data;
                cms_pkg::CFG_SEED2: seeds_reg[95:64]  <= cfg_data;
                cms_pkg::CFG_SEED3: seeds_reg[127:96] <= cfg_data;
                default:            rows_reg <= rows_reg;
            endcase
        end
    end

    cms_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_mode  (s_axis_tuser),
        .s_key   (s_axis_tdata),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_req   (q_req)
    );

    cms_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_req            (q_req),
        .rows_in_use      (rows_reg),
        .counters_per_row (cols_reg),
        .seeds            (seeds_reg),
        .m_valid          (m_axis_tvalid),
        .m_ready          (m_axis_tready),
        .estimate         (m_axis_tdata)
    );

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the count-min sketch engine. A behavioural sketch
// with its own SpookyHash row hash predicts every estimate. Directed, config
// sweep, random and back-pressure tests run in turn with random idling.
// ----------------------------------------------------------------------------
module tb;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;   // key_low[63:0], key_high[103:64]
    logic [1:0]   s_axis_tuser;   // mode
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;   // estimate
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    count_min_sketch_engine u_top (.*);

    // Sketch model state
    logic [31:0]  sketch_counts [cms_pkg::DEPTH];
    logic [2:0]   row_count_reg;
    logic [10:0]  column_count_reg;
    logic [31:0]  row_seeds [4];
    logic [31:0]  estimate_queue [$];

    int           mismatch_count;
    bit           no_idle;
    bit           hold_request;
    int           hold_cycles;
    logic [63:0]  pool_low [16];
    logic [39:0]  pool_high [16];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Time limit
    initial
    begin
        #200000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [63:0] rol64(input logic [63:0] x, input int k);
        return (x << k) | (x >> (64 - k));
    endfunction

    // SpookyHash V2 short path for a 13-byte key, low 32 bits of h0
    function automatic logic [31:0] row_hash(input logic [63:0] lo, input logic [39:0] hi,
                                             input logic [31:0] seed);
        logic [63:0] h0, h1, h2, h3;
        h0 = {32'd0, seed};
        h1 = {32'd0, seed};
        h2 = cms_pkg::SPOOKY_CONST + lo;
        h3 = cms_pkg::SPOOKY_CONST + {24'd0, hi} + (64'd13 << 56);
        h3 ^= h2; h2 = rol64(h2, 15); h3 += h2;
        h0 ^= h3; h3 = rol64(h3, 52); h0 += h3;
        h1 ^= h0; h0 = rol64(h0, 26); h1 += h0;
        h2 ^= h1; h1 = rol64(h1, 51); h2 += h1;
        h3 ^= h2; h2 = rol64(h2, 28); h3 += h2;
        h0 ^= h3; h3 = rol64(h3, 9);  h0 += h3;
        h1 ^= h0; h0 = rol64(h0, 47); h1 += h0;
        h2 ^= h1; h1 = rol64(h1, 54); h2 += h1;
        h3 ^= h2; h2 = rol64(h2, 32); h3 += h2;
        h0 ^= h3; h3 = rol64(h3, 25); h0 += h3;
        h1 ^= h0; h0 = rol64(h0, 63); h1 += h0;
        return h0[31:0];
    endfunction

    // Apply one request to the sketch and return its estimate
    function automatic logic [31:0] sketch_apply(input cms_pkg::mode_t mode,
                                                 input logic [63:0] lo,
                                                 input logic [39:0] hi);
        int rows, cols, col, addr;
        logic [31:0] best;
        best = '0;
        if (mode == cms_pkg::MODE_CLEAR)
        begin
            foreach (sketch_counts[i]) sketch_counts[i] = '0;
            return '0;
        end
        if (mode == cms_pkg::MODE_NONE)
            return '0;
        rows = (row_count_reg == 0) ? 1 :
               (row_count_reg > cms_pkg::ROWS) ? cms_pkg::ROWS : row_count_reg;
        cols = (column_count_reg == 0) ? 1 :
               (column_count_reg > cms_pkg::COLUMNS) ? cms_pkg::COLUMNS : column_count_reg;
        for (int r = 0; r < rows; r++)
        begin
            col  = row_hash(lo, hi, row_seeds[r]) % cols;
            addr = r * cols + col;
            if (mode == cms_pkg::MODE_UPDATE)
                sketch_counts[addr] = sketch_counts[addr] + 1;
            else if (r == 0 || sketch_counts[addr] < best)
                best = sketch_counts[addr];
        end
        return (mode == cms_pkg::MODE_QUERY) ? best : '0;
    endfunction

    // Send one request and record its expected estimate on acceptance
    task automatic send_request(input cms_pkg::mode_t mode, input logic [63:0] lo,
                                input logic [39:0] hi);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {hi, lo};
        do @(posedge clk); while (!s_axis_tready);
        estimate_queue.push_back(sketch_apply(mode, lo, hi));
    endtask

    // Idle the sender at random; valid stays high when there is no gap
    task automatic sender_gap();
        if (!no_idle && $urandom_range(0, 99) < 27)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Lower valid and wait until every estimate is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (estimate_queue.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input cms_pkg::cfg_idx_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            cms_pkg::CFG_ROWS:  row_count_reg    = value[2:0];
            cms_pkg::CFG_COLS:  column_count_reg = value[10:0];
            cms_pkg::CFG_SEED0: row_seeds[0]     = value;
            cms_pkg::CFG_SEED1: row_seeds[1]     = value;
            cms_pkg::CFG_SEED2: row_seeds[2]     = value;
            cms_pkg::CFG_SEED3: row_seeds[3]     = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Random request: mostly hot keys so counts build up
    task automatic send_random();
        int             pick, sel;
        cms_pkg::mode_t mode;
        pick = $urandom_range(0, 999);
        sel  = $urandom_range(0, 15);
        mode = (pick < 520) ? cms_pkg::MODE_UPDATE : (pick < 965) ? cms_pkg::MODE_QUERY :
               (pick < 980) ? cms_pkg::MODE_NONE : cms_pkg::MODE_CLEAR;
        if ($urandom_range(0, 3) == 0)
            send_request(mode, {$urandom, $urandom}, {8'($urandom), 32'($urandom)});
        else
            send_request(mode, pool_low[sel], pool_high[sel]);
        sender_gap();
    endtask

    // Receiver: check each estimate and drive ready
    initial
    begin
        m_axis_tready = 1'b0;
        hold_cycles   = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (estimate_queue.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected estimate %h", m_axis_tdata);
                end
                else
                begin
                    logic [31:0] want;
                    want = estimate_queue.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("estimate mismatch: expected %h actual %h",
                                     want, m_axis_tdata);
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request  = 1'b0;
                hold_cycles   = 600;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 27);
        end
    end

    // Field extremes, every mode, unused mode and clear
    task automatic test_directed();
        send_request(cms_pkg::MODE_QUERY,  '0, '0);                      sender_gap();
        send_request(cms_pkg::MODE_UPDATE, '0, '0);                      sender_gap();
        send_request(cms_pkg::MODE_UPDATE, '0, '0);                      sender_gap();
        send_request(cms_pkg::MODE_UPDATE, '1, '1);                      sender_gap();
        send_request(cms_pkg::MODE_QUERY,  '0, '0);                      sender_gap();
        send_request(cms_pkg::MODE_QUERY,  '1, '1);                      sender_gap();
        send_request(cms_pkg::MODE_NONE,   '1, '1);                      sender_gap();
        send_request(cms_pkg::MODE_QUERY,  '1, '1);                      sender_gap();
        send_request(cms_pkg::MODE_UPDATE, 64'h0123456789abcdef, 40'h55aa55aa55);
        sender_gap();
        send_request(cms_pkg::MODE_QUERY,  64'h0123456789abcdef, 40'h55aa55aa55);
        sender_gap();
        send_request(cms_pkg::MODE_QUERY,  64'hfedcba9876543210, 40'haa55aa55aa);
        sender_gap();
        send_request(cms_pkg::MODE_CLEAR,  '1, '1);                      sender_gap();
        send_request(cms_pkg::MODE_QUERY,  '0, '0);                      sender_gap();
        send_request(cms_pkg::MODE_QUERY,  '1, '1);                      sender_gap();
        send_request(cms_pkg::MODE_UPDATE, 64'h8000000000000001, 40'h8000000001);
        sender_gap();
        send_request(cms_pkg::MODE_QUERY,  64'h8000000000000001, 40'h8000000001);
        drain();
    endtask

    // Walk through row, column and seed settings, extremes included
    task automatic test_config_sweep();
        logic [2:0]  row_set [6]  = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd5, 3'd4};
        logic [10:0] col_set [6]  = '{11'd1, 11'd0, 11'd2047, 11'd3, 11'd1000, 11'd1024};
        for (int s = 0; s < 6; s++)
        begin
            write_reg(cms_pkg::CFG_ROWS, {29'd0, row_set[s]});
            // Layout change without clear on odd steps
            write_reg(cms_pkg::CFG_COLS, {$urandom_range(0, 1) ? 21'h1fffff : 21'd0, col_set[s]});
            write_reg(cms_pkg::CFG_SEED0, (s == 1) ? 32'hffffffff : $urandom);
            write_reg(cms_pkg::CFG_SEED1, (s == 1) ? 32'h0 : $urandom);
            write_reg(cms_pkg::CFG_SEED2, (s == 2) ? 32'hffffffff : $urandom);
            write_reg(cms_pkg::CFG_SEED3, (s == 2) ? 32'h0 : $urandom);
            if (s % 2 == 0)
            begin
                send_request(cms_pkg::MODE_CLEAR, '0, '0);
                sender_gap();
            end
            repeat (25) send_random();
            drain();
        end
    endtask

    // Bulk random traffic, part of it with no idling on either side
    task automatic test_random();
        write_reg(cms_pkg::CFG_ROWS, 32'd4);
        write_reg(cms_pkg::CFG_COLS, 32'd64);
        for (int i = 0; i < 500; i++)
        begin
            no_idle = (i >= 200 && i < 300);
            send_random();
        end
        no_idle = 1'b0;
        drain();
        write_reg(cms_pkg::CFG_COLS, 32'd1024);
        repeat (100) send_random();
        drain();
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 12; i++)
            send_random();
        drain();
        // Sender pauses until every estimate is back, then goes on
        repeat (10) send_random();
        drain();
        repeat (10) send_random();
        drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatch_count = 0;
        no_idle        = 1'b0;
        hold_request   = 1'b0;
        row_count_reg    = 3'd4;
        column_count_reg = 11'd1024;
        for (int r = 0; r < 4; r++) row_seeds[r] = r;
        foreach (sketch_counts[i]) sketch_counts[i] = '0;
        for (int k = 0; k < 16; k++)
        begin
            pool_low[k]  = {$urandom, $urandom};
            pool_high[k] = {8'($urandom), 32'($urandom)};
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_sweep();
        test_random();
        test_backpressure();

        if (mismatch_count == 0 && estimate_queue.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
